>>> design/button_click_long_press_classifier_assert.svh
// ----------------------------------------------------------------------------
// button click classifier assertion macros
// concurrent checks on the block clock, masked while reset is high
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_LONG_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_LONG_PRESS_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define BCLP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bclp check failed");
`define BCLP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bclp check failed");
`else
`define BCLP_ASSERT_NOW(lbl, ante, cons)
`define BCLP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/bclp_pkg.sv
// ----------------------------------------------------------------------------
// bclp_pkg
// types and constants of the button click and long-press classifier
// ----------------------------------------------------------------------------
package bclp_pkg;

   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned ReqDataWidth = 8;
   localparam int unsigned RspDataWidth = 24;
   localparam int unsigned LimitWidth   = 10;
   localparam int unsigned CountWidth   = 8;

   localparam logic [CountWidth-1:0] LongMark = 8'hFF;

   typedef enum logic [1:0] {
      EV_IDLE      = 2'd0,
      EV_PRESSED   = 2'd1,
      EV_REPRESSED = 2'd2,
      EV_LONG      = 2'd3
   } ev_state_type;

   typedef enum logic [2:0] {
      REG_PRESSED_LEVEL    = 3'd0,
      REG_DEBOUNCE_TICKS   = 3'd1,
      REG_REPRESS_TICKS    = 3'd2,
      REG_CLICK_DONE_TICKS = 3'd3,
      REG_LONG_PRESS_TICKS = 3'd4,
      REG_REPORT_ENABLE    = 3'd5,
      REG_SPARE_6          = 3'd6,
      REG_SPARE_7          = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [CountWidth-1:0] report_value;
      logic                  report_valid;
      logic [CountWidth-1:0] click_count;
      ev_state_type          event_state;
   } result_type;

endpackage

>>> design/button_click_long_press_classifier.sv
// ----------------------------------------------------------------------------
// button_click_long_press_classifier
// classifies scan ticks of one button pin into clicks, repeats and long presses
// ----------------------------------------------------------------------------
// Every req transfer is one scan tick carrying the sampled pin level and
// yields exactly one rsp transfer. Counter and compare update is combinational
// from the state registers, so a tick is accepted on every clock unless the
// skid register is full; a two-entry output buffer (result register plus skid
// register) keeps req_tready high until two results wait. Configuration goes
// through the APB-style csr port while no tick is in flight (user-enforced).
`include "button_click_long_press_classifier_assert.svh"

module button_click_long_press_classifier #(
   parameter int unsigned TICK_COUNTER_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [0] pin_level, [7:1] zero
   input  logic [bclp_pkg::ReqDataWidth-1:0]      req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [1:0] event_state, [9:2] click_count, [17:10] report_value, [23:18] zero
   output logic [bclp_pkg::RspDataWidth-1:0]      rsp_tdata,
   // [0] report_valid
   output logic                                   rsp_tuser,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [bclp_pkg::CsrAddrWidth-1:0]      csr_paddr,
   input  logic [bclp_pkg::CsrDataWidth-1:0]      csr_pwdata,
   output logic [bclp_pkg::CsrDataWidth-1:0]      csr_prdata,
   output logic                                   csr_pready
);
   import bclp_pkg::*;

   localparam logic [TICK_COUNTER_WIDTH-1:0] TickMax = '1;

   logic                    pressed_level_ff;
   logic [LimitWidth-1:0]   debounce_ticks_ff;
   logic [LimitWidth-1:0]   repress_ticks_ff;
   logic [LimitWidth-1:0]   click_done_ticks_ff;
   logic [LimitWidth-1:0]   long_press_ticks_ff;
   logic                    report_enable_ff;

   logic [TICK_COUNTER_WIDTH-1:0] pressed_ticks_ff, pressed_ticks_in;
   logic [TICK_COUNTER_WIDTH-1:0] released_ticks_ff, released_ticks_in;
   ev_state_type                  event_ff, event_in;
   logic [CountWidth-1:0]         count_ff, count_in;

   result_type out_ff, skid_ff, result;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;

   logic                          req_fire, rsp_fire, csr_write;
   reg_index_type                 csr_index;
   logic                          pin_pressed;
   logic [TICK_COUNTER_WIDTH-1:0] pressed_inc, released_inc;
   logic [TICK_COUNTER_WIDTH-1:0] long_limit, repress_limit, debounce_limit, done_limit;
   logic                          rep;
   logic [CountWidth-1:0]         rep_val;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.report_valid;
   assign rsp_tdata  = {{(RspDataWidth - 2 - 2 * CountWidth){1'b0}},
                        out_ff.report_value, out_ff.click_count, out_ff.event_state};

   // csr access
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_PRESSED_LEVEL:    csr_prdata[0] = pressed_level_ff;
         REG_DEBOUNCE_TICKS:   csr_prdata[LimitWidth-1:0] = debounce_ticks_ff;
         REG_REPRESS_TICKS:    csr_prdata[LimitWidth-1:0] = repress_ticks_ff;
         REG_CLICK_DONE_TICKS: csr_prdata[LimitWidth-1:0] = click_done_ticks_ff;
         REG_LONG_PRESS_TICKS: csr_prdata[LimitWidth-1:0] = long_press_ticks_ff;
         REG_REPORT_ENABLE:    csr_prdata[0] = report_enable_ff;
         default:              csr_prdata = '0;
      endcase
   end

   // tick classification
   assign pin_pressed    = (req_tdata[0] == pressed_level_ff);
   assign pressed_inc    = (pressed_ticks_ff == TickMax) ? TickMax : pressed_ticks_ff + 1'b1;
   assign released_inc   = (released_ticks_ff == TickMax) ? TickMax : released_ticks_ff + 1'b1;
   assign long_limit     = TICK_COUNTER_WIDTH'(long_press_ticks_ff);
   assign repress_limit  = TICK_COUNTER_WIDTH'(repress_ticks_ff);
   assign debounce_limit = TICK_COUNTER_WIDTH'(debounce_ticks_ff);
   assign done_limit     = TICK_COUNTER_WIDTH'(click_done_ticks_ff);

   always_comb begin
      pressed_ticks_in  = pressed_ticks_ff;
      released_ticks_in = released_ticks_ff;
      event_in          = event_ff;
      count_in          = count_ff;
      rep               = 1'b0;
      rep_val           = '0;
      if (pin_pressed) begin
         pressed_ticks_in = pressed_inc;
         if (pressed_inc < long_limit) begin
            event_in          = (released_ticks_ff < repress_limit) ? EV_REPRESSED : EV_PRESSED;
            released_ticks_in = '0;
         end else if (event_ff != EV_LONG) begin
            event_in = EV_LONG;
            count_in = LongMark;
            if (report_enable_ff) begin
               rep      = 1'b1;
               rep_val  = LongMark;
               count_in = '0;
            end
         end
      end else begin
         released_ticks_in = released_inc;
         if (pressed_ticks_ff > debounce_limit) begin
            pressed_ticks_in = '0;
            unique case (event_ff)
               EV_REPRESSED: count_in = count_ff + 1'b1;
               EV_PRESSED:   count_in = CountWidth'(1);
               EV_LONG:      event_in = EV_IDLE;
               default:      event_in = event_ff;
            endcase
         end
         if ((released_inc > done_limit) && report_enable_ff && (event_in != EV_IDLE)) begin
            rep      = 1'b1;
            rep_val  = count_in;
            count_in = '0;
            event_in = EV_IDLE;
         end
      end
      result.event_state  = event_in;
      result.click_count  = count_in;
      result.report_valid = rep;
      result.report_value = rep_val;
   end

   // output buffer
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_fire) begin
         out_valid_in  = skid_valid_ff || req_fire;
         skid_valid_in = 1'b0;
      end else if (req_fire) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_level_ff    <= 1'b0;
         debounce_ticks_ff   <= LimitWidth'(5);
         repress_ticks_ff    <= LimitWidth'(15);
         click_done_ticks_ff <= LimitWidth'(25);
         long_press_ticks_ff <= LimitWidth'(100);
         report_enable_ff    <= 1'b1;
         pressed_ticks_ff    <= '0;
         released_ticks_ff   <= '0;
         event_ff            <= EV_IDLE;
         count_ff            <= '0;
         out_valid_ff        <= 1'b0;
         skid_valid_ff       <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_PRESSED_LEVEL:    pressed_level_ff    <= csr_pwdata[0];
               REG_DEBOUNCE_TICKS:   debounce_ticks_ff   <= csr_pwdata[LimitWidth-1:0];
               REG_REPRESS_TICKS:    repress_ticks_ff    <= csr_pwdata[LimitWidth-1:0];
               REG_CLICK_DONE_TICKS: click_done_ticks_ff <= csr_pwdata[LimitWidth-1:0];
               REG_LONG_PRESS_TICKS: long_press_ticks_ff <= csr_pwdata[LimitWidth-1:0];
               REG_REPORT_ENABLE:    report_enable_ff    <= csr_pwdata[0];
               default:              report_enable_ff    <= report_enable_ff;
            endcase
         end
         if (req_fire) begin
            pressed_ticks_ff  <= pressed_ticks_in;
            released_ticks_ff <= released_ticks_in;
            event_ff          <= event_in;
            count_ff          <= count_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_fire) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (req_fire) begin
         skid_ff <= result;
      end
   end

   `BCLP_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   `BCLP_ASSERT_NEXT(a_stall_fills_skid, req_fire && out_valid_ff && !rsp_fire, skid_valid_ff)
   `BCLP_ASSERT_NOW(a_report_leaves_idle_or_long, out_valid_ff && out_ff.report_valid,
      (out_ff.event_state == EV_IDLE) || (out_ff.event_state == EV_LONG))
   `BCLP_ASSERT_NOW(a_long_count_marked, event_ff == EV_LONG,
      (count_ff == LongMark) || (count_ff == '0))

endmodule
